@@ hw/rtl/etspm_pkg.sv @@
`default_nettype none
package etspm_pkg;

   // most merged pulses in one capture
   localparam int unsigned MAX_PULSES = 511;
   localparam int unsigned CNT_W      = $clog2(MAX_PULSES + 1);

   // edge to pulse queue depth
   localparam int unsigned CMD_DEPTH  = 4;
   localparam int unsigned CMD_PTR_W  = $clog2(CMD_DEPTH);

   // result queue depth, room for two words per edge
   localparam int unsigned RES_DEPTH  = 4;
   localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);

   localparam logic [30:0] DUR_MAX    = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0] edge_time_us;
      logic        edge_level;
      logic        capture_end;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] signed_duration;
      logic               final_of_capture;
      logic               empty_capture;
   } rsp_word_type;

   // classified edge handed from front to back
   typedef struct packed {
      logic        has_gap;
      logic        gap_level;
      logic [30:0] gap;
      logic        last;
   } cmd_word_type;

   // clamp a 32 bit magnitude to the 31 bit duration range
   function automatic logic [30:0] sat31(input logic [31:0] v);
      sat31 = v[31] ? DUR_MAX : v[30:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/etspm_front.sv @@
`default_nettype none
module etspm_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    take,
   input  wire etspm_pkg::req_word_type word,
   output      etspm_pkg::cmd_word_type cmd
);
   import etspm_pkg::*;

   logic        have_prior_ff, have_prior_in;
   logic [31:0] prior_time_ff, prior_time_in;
   logic        prior_level_ff, prior_level_in;
   logic [31:0] diff;

   always_comb begin
      diff          = word.edge_time_us - prior_time_ff;
      cmd.has_gap   = have_prior_ff;
      cmd.gap_level = prior_level_ff;
      cmd.gap       = sat31(diff);
      cmd.last      = word.capture_end;
   end

   always_comb begin
      have_prior_in  = have_prior_ff;
      prior_time_in  = prior_time_ff;
      prior_level_in = prior_level_ff;
      if (take) begin
         have_prior_in  = !word.capture_end;
         prior_time_in  = word.edge_time_us;
         prior_level_in = word.edge_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prior_ff <= 1'b0;
      end else begin
         have_prior_ff <= have_prior_in;
      end
      prior_time_ff  <= prior_time_in;
      prior_level_ff <= prior_level_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/etspm_cmd_fifo.sv @@
`default_nettype none
module etspm_cmd_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire etspm_pkg::cmd_word_type push_word,
   output      logic                    full,
   input  wire logic                    pop,
   output      etspm_pkg::cmd_word_type pop_word,
   output      logic                    empty
);
   import etspm_pkg::*;

   cmd_word_type             mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CMD_PTR_W:0]       cnt_ff, cnt_in;
   logic                     do_push, do_pop;

   always_comb begin
      full     = (cnt_ff == (CMD_PTR_W+1)'(CMD_DEPTH));
      empty    = (cnt_ff == '0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_word = mem_ff[rd_ff];
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in   = cnt_ff + (CMD_PTR_W+1)'(do_push) - (CMD_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/etspm_back.sv @@
`default_nettype none
module etspm_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire etspm_pkg::cmd_word_type cmd,
   input  wire logic                    cmd_empty,
   output      logic                    cmd_pop,
   output      logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   output      etspm_pkg::rsp_word_type rsp_word
);
   import etspm_pkg::*;

   // pulse being merged
   logic             open_ff, open_in;
   logic [30:0]      len_ff, len_in;
   logic             lvl_ff, lvl_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             stop_ff, stop_in;
   logic             emitted_ff, emitted_in;

   // result queue
   rsp_word_type         res_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RES_PTR_W:0]   fill_ff, fill_in;

   logic             act, merge, close_a, close_b, emit_a, emit_b, fin_a, marker;
   logic             stop1, emitted1, open1, lvl1;
   logic [30:0]      len1;
   logic [CNT_W:0]   cnt_a, cnt_b;
   logic [CNT_W-1:0] cnt1;
   logic             do_pop;
   logic             v0, v1;
   rsp_word_type     r0, r1, word_a, word_b, word_m;

   always_comb begin
      rsp_empty = (fill_ff == '0);
      rsp_word  = res_ff[rd_ff];
      do_pop    = rsp_pop && !rsp_empty;
      // need room for two words
      cmd_pop   = !cmd_empty && (fill_ff <= (RES_PTR_W+1)'(RES_DEPTH - 2));
      act       = cmd_pop;

      merge   = !stop_ff && cmd.has_gap;
      close_a = merge && open_ff && (cmd.gap_level != lvl_ff);
      cnt_a   = {1'b0, cnt_ff} + 1'b1;
      fin_a   = (cnt_a >= (CNT_W+1)'(MAX_PULSES));
      emit_a  = close_a && !(cnt_a == (CNT_W+1)'(1) && !lvl_ff);
      word_a.signed_duration  = lvl_ff ? {1'b0, len_ff} : 32'd0 - {1'b0, len_ff};
      word_a.final_of_capture = fin_a;
      word_a.empty_capture    = 1'b0;

      stop1    = stop_ff || (close_a && fin_a);
      emitted1 = emitted_ff || emit_a;
      cnt1     = close_a ? cnt_a[CNT_W-1:0] : cnt_ff;
      open1    = open_ff || merge;
      len1     = len_ff;
      lvl1     = lvl_ff;
      if (merge) begin
         if (open_ff && (cmd.gap_level == lvl_ff)) begin
            len1 = sat31({1'b0, len_ff} + {1'b0, cmd.gap});
         end else begin
            len1 = cmd.gap;
            lvl1 = cmd.gap_level;
         end
      end

      // flush on the last edge
      close_b = cmd.last && !stop1 && open1;
      cnt_b   = {1'b0, cnt1} + 1'b1;
      emit_b  = close_b && !(cnt_b == (CNT_W+1)'(1) && !lvl1);
      word_b.signed_duration  = lvl1 ? {1'b0, len1} : 32'd0 - {1'b0, len1};
      word_b.final_of_capture = 1'b1;
      word_b.empty_capture    = 1'b0;

      marker = cmd.last && !emitted1 && !emit_b;
      word_m.signed_duration  = '0;
      word_m.final_of_capture = 1'b1;
      word_m.empty_capture    = 1'b1;

      // a marker never follows an emitted pulse, so two words means a then b
      v0 = act && (emit_a || emit_b || marker);
      v1 = act && emit_a && emit_b;
      r0 = emit_a ? word_a : (emit_b ? word_b : word_m);
      r1 = word_b;

      open_in    = open_ff;
      len_in     = len_ff;
      lvl_in     = lvl_ff;
      cnt_in     = cnt_ff;
      stop_in    = stop_ff;
      emitted_in = emitted_ff;
      if (act) begin
         if (cmd.last) begin
            open_in    = 1'b0;
            len_in     = '0;
            lvl_in     = 1'b0;
            cnt_in     = '0;
            stop_in    = 1'b0;
            emitted_in = 1'b0;
         end else begin
            open_in    = open1;
            len_in     = len1;
            lvl_in     = lvl1;
            cnt_in     = cnt1;
            stop_in    = stop1;
            emitted_in = emitted1;
         end
      end

      wr_in   = wr_ff + RES_PTR_W'(v0) + RES_PTR_W'(v1);
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (RES_PTR_W+1)'(v0) + (RES_PTR_W+1)'(v1)
                - (RES_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         len_ff     <= '0;
         lvl_ff     <= 1'b0;
         cnt_ff     <= '0;
         stop_ff    <= 1'b0;
         emitted_ff <= 1'b0;
         wr_ff      <= '0;
         rd_ff      <= '0;
         fill_ff    <= '0;
      end else begin
         open_ff    <= open_in;
         len_ff     <= len_in;
         lvl_ff     <= lvl_in;
         cnt_ff     <= cnt_in;
         stop_ff    <= stop_in;
         emitted_ff <= emitted_in;
         wr_ff      <= wr_in;
         rd_ff      <= rd_in;
         fill_ff    <= fill_in;
      end
      if (v0) begin
         res_ff[wr_ff] <= r0;
      end
      if (v1) begin
         res_ff[wr_ff + 1'b1] <= r1;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/edge_to_signed_pulse_merger_core.sv @@
`default_nettype none
// channel   direction  handshake            word
// req       in         req_push / req_full   req_word  (edge time, level, capture end)
// rsp       out        rsp_pop / rsp_empty   rsp_word  (signed duration, final, empty)
//
// one edge can be taken every cycle while req_full is low; the front registers
// the previous edge and queues a classified gap, the back merges it and writes up
// to two words into a four-deep result queue; a word passes from its taken edge
// through the gap queue and the result queue, then sits on the result ports
// the back pauses on an empty gap queue or fewer than two free result places
// reset is synchronous and clears both queues and the merge state at once
module edge_to_signed_pulse_merger_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output      logic                    req_full,
   input  wire etspm_pkg::req_word_type req_word,
   output      logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   output      etspm_pkg::rsp_word_type rsp_word
);
   import etspm_pkg::*;

   cmd_word_type front_cmd;   // gap classified at the front
   cmd_word_type back_cmd;    // oldest queued gap
   logic         take;
   logic         cmd_empty;
   logic         cmd_pop;

   // edge accepted when the gap queue has room
   assign take = req_push && !req_full;

   etspm_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .word  (req_word),
      .cmd   (front_cmd)
   );

   // short queue so front and back stall on their own
   etspm_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_word (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_word  (back_cmd),
      .empty     (cmd_empty)
   );

   // pulse merging, flushing and result queue
   etspm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire
